[sv/integer_to_ascii_formatter_assert.svh]
// integer_to_ascii_formatter_assert.svh: assertion macros for the formatter
// no dependencies; included by the top level only
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IAF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/iaf_pkg.sv]
// iaf_pkg.sv: types and constants of the integer to ascii formatter
// no dependencies; used by iaf_digit_cell and integer_to_ascii_formatter
`timescale 1ns / 1ps

package iaf_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int HEX_DIGITS = VALUE_W / 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO          = 8'h30;
  localparam logic [7:0] ASCII_LETTER_OFFSET = 8'h37;
  localparam logic [7:0] ASCII_X             = 8'h78;
  localparam logic [7:0] ASCII_MINUS         = 8'h2D;
  localparam logic [3:0] MAX_DEC_DIGIT       = 4'h9;

  typedef enum logic [1:0] {
    CMD_HEX  = 2'd0,
    CMD_UDEC = 2'd1,
    CMD_SDEC = 2'd2,
    CMD_NONE = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PRE0,
    ST_PREX,
    ST_MINUS,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } result_t;

endpackage

[sv/iaf_digit_cell.sv]
// iaf_digit_cell.sv: one 4-bit digit cell of the shift-add-3 chain
// depends on iaf_pkg
`timescale 1ns / 1ps

module iaf_digit_cell (
  input  logic              clk,
  input  iaf_pkg::cell_ctrl_t ctrl,
  input  logic [3:0]        load_digit,
  input  logic              carry_in,
  input  logic [3:0]        digit_in,
  output logic [3:0]        digit,
  output logic              carry_out
);

  logic [3:0] adjusted;
  logic [3:0] digit_next;

  // add 3 when the digit would reach ten or more after doubling
  assign adjusted  = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign carry_out = adjusted[3];

  always_comb begin
    case (ctrl.op)
      iaf_pkg::CELL_LOAD:   digit_next = load_digit;
      iaf_pkg::CELL_DABBLE: digit_next = {adjusted[2:0], carry_in};
      iaf_pkg::CELL_SHIFT:  digit_next = digit_in;
      default:              digit_next = digit;
    endcase
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

[sv/integer_to_ascii_formatter.sv]
// integer_to_ascii_formatter.sv: top level, control sequencer and digit chain
// depends on iaf_pkg, iaf_digit_cell and integer_to_ascii_formatter_assert.svh
`timescale 1ns / 1ps
// Usage:
//   A transfer in happens at a rising edge with start high and busy low; item
//   carries the format command and the 32-bit value. Busy stays high until the
//   last character has been put out.
//   Characters leave on result, marked by strobe and never more than one per cycle,
//   with result.last set on the final one. The receiver cannot stall the block.
//   Hex: "0x" plus digits; the first character is chosen in state PRE0, entered on
//   the transfer, and reaches result through the result register.
//   Decimal: a row of ten digit cells runs shift-add-3 over the 32 value bits,
//   one bit a cycle, then shifts digits out toward the top cell, one a cycle.
//   The minus sign of a negative signed item goes out between the conversion
//   loop and the ten-digit scan.
//   Command 3 is taken and gives no characters.
//   Reset (synchronous) returns the sequencer to idle and drops strobe.

module integer_to_ascii_formatter (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  iaf_pkg::item_t   item,
  output logic             busy,
  output logic             strobe,
  output iaf_pkg::result_t result
);

  `include "integer_to_ascii_formatter_assert.svh"

  iaf_pkg::state_t   state, state_next;
  logic [iaf_pkg::VALUE_W-1:0]   mag, mag_next;
  logic [iaf_pkg::BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [iaf_pkg::DIG_CNT_W-1:0] dig_cnt, dig_cnt_next;
  logic              neg, neg_next;
  logic              started, started_next;
  logic              strobe_next;
  iaf_pkg::result_t  result_next;
  iaf_pkg::cell_ctrl_t cell_ctrl;
  logic              accept;
  logic              is_hex;
  logic [3:0]        top_digit;

  logic [3:0] digits    [iaf_pkg::NUM_DIGITS];
  logic [3:0] load_dig  [iaf_pkg::NUM_DIGITS];
  logic       carries   [iaf_pkg::NUM_DIGITS];

  assign accept    = start && !busy;
  assign busy      = (state != iaf_pkg::ST_IDLE);
  assign is_hex    = (item.command == iaf_pkg::CMD_HEX);
  assign top_digit = digits[iaf_pkg::NUM_DIGITS-1];

  genvar g;
  generate
    for (g = 0; g < iaf_pkg::NUM_DIGITS; g++) begin : g_cell
      logic       cin;
      logic [3:0] din;
      if (g < iaf_pkg::HEX_DIGITS) begin : g_hex
        assign load_dig[g] = is_hex ? item.value[4*g +: 4] : 4'd0;
      end else begin : g_pad
        assign load_dig[g] = 4'd0;
      end
      if (g == 0) begin : g_bottom
        assign cin = mag[iaf_pkg::VALUE_W-1];
        assign din = 4'd0;
      end else begin : g_upper
        assign cin = carries[g-1];
        assign din = digits[g-1];
      end
      iaf_digit_cell u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .load_digit (load_dig[g]),
        .carry_in   (cin),
        .digit_in   (din),
        .digit      (digits[g]),
        .carry_out  (carries[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= iaf_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
    mag     <= mag_next;
    bit_cnt <= bit_cnt_next;
    dig_cnt <= dig_cnt_next;
    neg     <= neg_next;
    started <= started_next;
    result  <= result_next;
  end

  always_comb begin
    state_next   = state;
    mag_next     = mag;
    bit_cnt_next = bit_cnt;
    dig_cnt_next = dig_cnt;
    neg_next     = neg;
    started_next = started;
    strobe_next  = 1'b0;
    result_next  = result;
    cell_ctrl.op = iaf_pkg::CELL_HOLD;
    unique case (state)
      iaf_pkg::ST_IDLE: begin
        if (accept) begin
          cell_ctrl.op = iaf_pkg::CELL_LOAD;
          neg_next     = (item.command == iaf_pkg::CMD_SDEC) &&
                         item.value[iaf_pkg::VALUE_W-1];
          mag_next     = neg_next ? (~item.value + 1'b1) : item.value;
          bit_cnt_next = '0;
          dig_cnt_next = iaf_pkg::DIG_CNT_W'(iaf_pkg::NUM_DIGITS);
          started_next = 1'b0;
          if (is_hex) begin
            state_next = iaf_pkg::ST_PRE0;
          end else if (item.command == iaf_pkg::CMD_UDEC ||
                       item.command == iaf_pkg::CMD_SDEC) begin
            state_next = iaf_pkg::ST_CONV;
          end
        end
      end
      iaf_pkg::ST_CONV: begin
        cell_ctrl.op = iaf_pkg::CELL_DABBLE;
        mag_next     = {mag[iaf_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == iaf_pkg::BIT_CNT_W'(iaf_pkg::VALUE_W - 1)) begin
          state_next = neg ? iaf_pkg::ST_MINUS : iaf_pkg::ST_EMIT;
        end
      end
      iaf_pkg::ST_PRE0: begin
        strobe_next = 1'b1;
        result_next = '{character: iaf_pkg::ASCII_ZERO, last: 1'b0};
        state_next  = iaf_pkg::ST_PREX;
      end
      iaf_pkg::ST_PREX: begin
        strobe_next = 1'b1;
        result_next = '{character: iaf_pkg::ASCII_X, last: 1'b0};
        state_next  = iaf_pkg::ST_EMIT;
      end
      iaf_pkg::ST_MINUS: begin
        strobe_next = 1'b1;
        result_next = '{character: iaf_pkg::ASCII_MINUS, last: 1'b0};
        state_next  = iaf_pkg::ST_EMIT;
      end
      iaf_pkg::ST_EMIT: begin
        // top cell is the next digit; leading zeros dropped, the final one kept
        cell_ctrl.op = iaf_pkg::CELL_SHIFT;
        dig_cnt_next = dig_cnt - 1'b1;
        if (started || top_digit != 4'd0 || dig_cnt == 1) begin
          started_next          = 1'b1;
          strobe_next           = 1'b1;
          result_next.character = (top_digit > iaf_pkg::MAX_DEC_DIGIT)
                                  ? {4'd0, top_digit} + iaf_pkg::ASCII_LETTER_OFFSET
                                  : {4'd0, top_digit} + iaf_pkg::ASCII_ZERO;
          result_next.last      = (dig_cnt == 1);
        end
        if (dig_cnt == 1) begin
          state_next = iaf_pkg::ST_IDLE;
        end
      end
      default: state_next = iaf_pkg::ST_IDLE;
    endcase
  end

  `IAF_ASSERT_NEXT(a_gap_after_last, clk, rst, strobe && result.last, !strobe, "strobe right after last")
  `IAF_ASSERT_NEXT(a_none_cmd_idle, clk, rst, accept && item.command == iaf_pkg::CMD_NONE, !busy && !strobe, "unused command not dropped")
  `IAF_ASSERT_NOW(a_strobe_from_busy, clk, rst, strobe, $past(busy), "strobe without work in progress")
  `IAF_ASSERT_NOW(a_conv_quiet, clk, rst, state == iaf_pkg::ST_CONV && bit_cnt != 0, !strobe, "character during conversion")

endmodule

[sim/integer_to_ascii_formatter_tb.sv]
// integer_to_ascii_formatter_tb.sv: self-checking bench for the number formatter
// depends on iaf_pkg and integer_to_ascii_formatter; directed table then random
// items, every character checked against literal text or a local text predictor
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

  localparam int          RANDOM_ITEMS = 425;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 50;
  localparam int          MAX_REPORTS  = 10;
  localparam logic [31:0] TOP_PLACE    = 32'd1000000000;

  typedef struct {
    iaf_pkg::command_t cmd;
    logic [31:0]       value;
    bit                typed;
    string             text;
  } dir_row_t;

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  iaf_pkg::item_t   item  = '0;
  logic             busy;
  logic             strobe;
  iaf_pkg::result_t result;

  iaf_pkg::result_t pending_chars[$];
  int      fail_count    = 0;
  int      chars_checked = 0;
  int      idle_cycles   = 0;
  int      burst_left    = 0;
  int      items_per_cmd[4];

  integer_to_ascii_formatter i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always #2 clk = ~clk;

  function automatic void report_failure(string msg);
    if (fail_count < MAX_REPORTS) $display("mismatch: %s", msg);
    fail_count++;
  endfunction

  // characters the formatter should put out for one accepted item
  function automatic void predict_text(iaf_pkg::command_t cmd, logic [31:0] value);
    iaf_pkg::result_t chars[$];
    logic [31:0] mag;
    logic [31:0] place;
    logic [3:0]  nib;
    logic [7:0]  ch;
    bit          lead;
    mag  = value;
    lead = 1'b0;
    case (cmd)
      iaf_pkg::CMD_HEX: begin
        chars.push_back('{iaf_pkg::ASCII_ZERO, 1'b0});
        chars.push_back('{iaf_pkg::ASCII_X, 1'b0});
        for (int pos = 28; pos >= 0; pos -= 4) begin
          nib = mag[pos +: 4];
          if (nib != 4'h0) lead = 1'b1;
          if (lead || pos == 0) begin
            ch = (nib > iaf_pkg::MAX_DEC_DIGIT) ? iaf_pkg::ASCII_LETTER_OFFSET + nib
                                                : iaf_pkg::ASCII_ZERO + nib;
            chars.push_back('{ch, 1'b0});
          end
        end
      end
      iaf_pkg::CMD_UDEC, iaf_pkg::CMD_SDEC: begin
        if (cmd == iaf_pkg::CMD_SDEC && value[31]) begin
          chars.push_back('{iaf_pkg::ASCII_MINUS, 1'b0});
          mag = 32'd0 - value;
        end
        place = TOP_PLACE;
        for (int i = 0; i < 10; i++) begin
          nib   = 4'(mag / place);
          mag   = mag % place;
          if (nib != 4'h0) lead = 1'b1;
          if (lead || place == 32'd1) begin
            ch = iaf_pkg::ASCII_ZERO + nib;
            chars.push_back('{ch, 1'b0});
          end
          place = place / 10;
        end
      end
      default: ;
    endcase
    if (chars.size() != 0) chars[chars.size()-1].last = 1'b1;
    foreach (chars[i]) pending_chars.push_back(chars[i]);
  endfunction

  function automatic void expect_literal(string text);
    for (int i = 0; i < text.len(); i++)
      pending_chars.push_back('{8'(text[i]), i == text.len() - 1});
  endfunction

  // mostly back to back or short gaps, now and then a long one or a burst
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(0, 9))
      4: return 32'($urandom_range(0, 120));
      5: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      6: return 32'd0 - 32'($urandom_range(1, 1000));
      7: return 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2;
      8: return 32'($urandom_range(1, 15)) << (4 * $urandom_range(0, 7));
      9: return 32'($urandom) >> $urandom_range(0, 31);
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic send_item(iaf_pkg::command_t cmd, logic [31:0] value, bit typed,
                           string text);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      start         = 1'b0;
      item.command  = 2'($urandom_range(0, 3));
      item.value    = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        = 1'b1;
    item.command = cmd;
    item.value   = value;
    do @(posedge clk); while (busy);
    if (typed) expect_literal(text);
    else predict_text(cmd, value);
    items_per_cmd[cmd]++;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    iaf_pkg::result_t want;
    if (!rst) begin
      if ((start && !busy) || strobe) idle_cycles = 0;
      else idle_cycles++;
      if (strobe) begin
        if (pending_chars.size() == 0) begin
          report_failure($sformatf("unexpected character %h last %b",
                                   result.character, result.last));
        end else begin
          want = pending_chars.pop_front();
          chars_checked++;
          if (result.character !== want.character)
            report_failure($sformatf("character expected %h got %h",
                                     want.character, result.character));
          if (result.last !== want.last)
            report_failure($sformatf("last flag on %h expected %b got %b",
                                     want.character, want.last, result.last));
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d characters outstanding",
                 IDLE_LIMIT, pending_chars.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t          rows[$];
    int                sent;
    int                r;
    iaf_pkg::command_t cmd;
    sent = 0;
    foreach (items_per_cmd[i]) items_per_cmd[i] = 0;

    rows.push_back('{iaf_pkg::CMD_HEX,  32'h0000_0000, 1'b1, "0x0"});
    rows.push_back('{iaf_pkg::CMD_UDEC, 32'h0000_0000, 1'b1, "0"});
    rows.push_back('{iaf_pkg::CMD_SDEC, 32'h0000_0000, 1'b1, "0"});
    rows.push_back('{iaf_pkg::CMD_HEX,  32'hFFFF_FFFF, 1'b1, "0xFFFFFFFF"});
    rows.push_back('{iaf_pkg::CMD_UDEC, 32'hFFFF_FFFF, 1'b1, "4294967295"});
    rows.push_back('{iaf_pkg::CMD_SDEC, 32'hFFFF_FFFF, 1'b1, "-1"});
    rows.push_back('{iaf_pkg::CMD_SDEC, 32'h8000_0000, 1'b1, "-2147483648"});
    rows.push_back('{iaf_pkg::CMD_SDEC, 32'h7FFF_FFFF, 1'b1, "2147483647"});
    rows.push_back('{iaf_pkg::CMD_UDEC, 32'h8000_0000, 1'b1, "2147483648"});
    rows.push_back('{iaf_pkg::CMD_HEX,  32'h8000_0000, 1'b1, "0x80000000"});
    rows.push_back('{iaf_pkg::CMD_HEX,  32'h0000_0001, 1'b1, "0x1"});
    rows.push_back('{iaf_pkg::CMD_HEX,  32'h0000_0009, 1'b1, "0x9"});
    rows.push_back('{iaf_pkg::CMD_HEX,  32'h0000_000A, 1'b1, "0xA"});
    rows.push_back('{iaf_pkg::CMD_UDEC, 32'd1,         1'b1, "1"});
    rows.push_back('{iaf_pkg::CMD_UDEC, 32'd9,         1'b1, "9"});
    rows.push_back('{iaf_pkg::CMD_UDEC, 32'd10,        1'b1, "10"});
    rows.push_back('{iaf_pkg::CMD_UDEC, 32'd999999999, 1'b1, "999999999"});
    rows.push_back('{iaf_pkg::CMD_UDEC, TOP_PLACE,     1'b1, "1000000000"});
    rows.push_back('{iaf_pkg::CMD_SDEC, 32'hFFFF_FFF6, 1'b1, "-10"});
    // unused command is taken but produces nothing
    rows.push_back('{iaf_pkg::CMD_NONE, 32'h0000_0000, 1'b1, ""});
    rows.push_back('{iaf_pkg::CMD_NONE, 32'hFFFF_FFFF, 1'b1, ""});
    rows.push_back('{iaf_pkg::CMD_SDEC, 32'h8000_0001, 1'b0, ""});
    rows.push_back('{iaf_pkg::CMD_HEX,  32'h0F0F_0F0F, 1'b0, ""});
    rows.push_back('{iaf_pkg::CMD_HEX,  32'h1234_ABCD, 1'b0, ""});
    rows.push_back('{iaf_pkg::CMD_UDEC, 32'h5555_AAAA, 1'b0, ""});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_item(rows[i].cmd, rows[i].value, rows[i].typed, rows[i].text);

    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      cmd = (r == 0) ? iaf_pkg::CMD_NONE : iaf_pkg::command_t'((r - 1) % 3);
      send_item(cmd, pick_value(), 1'b0, "");
      sent++;
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("items: %0d hex, %0d unsigned, %0d signed, %0d unused command",
             items_per_cmd[iaf_pkg::CMD_HEX], items_per_cmd[iaf_pkg::CMD_UDEC],
             items_per_cmd[iaf_pkg::CMD_SDEC], items_per_cmd[iaf_pkg::CMD_NONE]);
    $display("characters checked: %0d, failures: %0d", chars_checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/iaf_pkg.sv
sv/iaf_digit_cell.sv
sv/integer_to_ascii_formatter.sv
sim/integer_to_ascii_formatter_tb.sv
